@@ rtl/tbgd_pkg.sv @@
package tbgd_pkg;

  // field widths fixed by the interface
  localparam int NOW_W      = 32;
  localparam int READING_W  = 16;
  localparam int LEVEL_W    = 16;
  localparam int SHORT_W    = 16;
  localparam int LONG_W     = 20;
  localparam int CMP_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // parameter defaults
  localparam int DEF_BASELINE_FRAC_BITS = 16;
  localparam int DEF_TIME_BITS          = 32;

  // baseline filter, alpha = 5243 / 2^16
  localparam int ALPHA_SHIFT = 16;
  localparam int ALPHA_ONE   = 65536;
  localparam int ALPHA_NUM   = 5243;
  localparam logic [15:0] ALPHA_KEEP_W = 16'(ALPHA_ONE - ALPHA_NUM);
  localparam logic [15:0] ALPHA_NUM_W  = 16'(ALPHA_NUM);
  localparam logic [15:0] ROUND_HALF_W = 16'(ALPHA_ONE / 2);

  // register reset values
  localparam logic [15:0] RST_CHECK_INTERVAL   = 16'd0;
  localparam logic [15:0] RST_DEBOUNCE_TIME    = 16'd50;
  localparam logic [15:0] RST_SHORT_TAP_MAX    = 16'd400;
  localparam logic [19:0] RST_LONG_PRESS_TIME  = 20'd1500;
  localparam logic [19:0] RST_VERY_LONG_TIME   = 20'd10000;
  localparam logic [15:0] RST_DOUBLE_TAP_WIN   = 16'd350;
  localparam logic [15:0] RST_TOUCH_MARGIN     = 16'd20;
  localparam logic [15:0] RST_INITIAL_BASELINE = 16'd0;

  typedef enum logic [2:0] {
    REG_CHECK_INTERVAL   = 3'd0,
    REG_DEBOUNCE_TIME    = 3'd1,
    REG_SHORT_TAP_MAX    = 3'd2,
    REG_LONG_PRESS_TIME  = 3'd3,
    REG_VERY_LONG_TIME   = 3'd4,
    REG_DOUBLE_TAP_WIN   = 3'd5,
    REG_TOUCH_MARGIN     = 3'd6,
    REG_INITIAL_BASELINE = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE            = 3'd0,
    EV_SHORT_TAP       = 3'd1,
    EV_DOUBLE_TAP      = 3'd2,
    EV_LONG_PRESS      = 3'd3,
    EV_VERY_LONG_PRESS = 3'd4
  } gesture_ev_t;

  typedef struct packed {
    logic [15:0] check_interval;
    logic [15:0] debounce_time;
    logic [15:0] short_tap_max;
    logic [19:0] long_press_time;
    logic [19:0] very_long_press_time;
    logic [15:0] double_tap_window;
    logic [15:0] touch_margin;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [15:0] value;
  } base_load_t;

  typedef struct packed {
    gesture_ev_t ev;
    logic        stable;
    logic        raw;
    logic [15:0] level;
  } result_t;

endpackage

@@ rtl/tbgd_cfg.sv @@
module tbgd_cfg
  import tbgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg,
  output base_load_t            base_load
);

  logic        wr_en;
  reg_idx_t    idx;
  logic [15:0] initial_baseline;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval       <= RST_CHECK_INTERVAL;
      cfg.debounce_time        <= RST_DEBOUNCE_TIME;
      cfg.short_tap_max        <= RST_SHORT_TAP_MAX;
      cfg.long_press_time      <= RST_LONG_PRESS_TIME;
      cfg.very_long_press_time <= RST_VERY_LONG_TIME;
      cfg.double_tap_window    <= RST_DOUBLE_TAP_WIN;
      cfg.touch_margin         <= RST_TOUCH_MARGIN;
      initial_baseline         <= RST_INITIAL_BASELINE;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHECK_INTERVAL:   cfg.check_interval       <= pwdata[15:0];
        REG_DEBOUNCE_TIME:    cfg.debounce_time        <= pwdata[15:0];
        REG_SHORT_TAP_MAX:    cfg.short_tap_max        <= pwdata[15:0];
        REG_LONG_PRESS_TIME:  cfg.long_press_time      <= pwdata[19:0];
        REG_VERY_LONG_TIME:   cfg.very_long_press_time <= pwdata[19:0];
        REG_DOUBLE_TAP_WIN:   cfg.double_tap_window    <= pwdata[15:0];
        REG_TOUCH_MARGIN:     cfg.touch_margin         <= pwdata[15:0];
        REG_INITIAL_BASELINE: initial_baseline         <= pwdata[15:0];
      endcase
    end
  end

  // baseline load pulse goes straight to the tracking state
  assign base_load.load  = wr_en && (idx == REG_INITIAL_BASELINE);
  assign base_load.value = pwdata[15:0];

  always_comb begin
    unique case (idx)
      REG_CHECK_INTERVAL:   prdata = 32'(cfg.check_interval);
      REG_DEBOUNCE_TIME:    prdata = 32'(cfg.debounce_time);
      REG_SHORT_TAP_MAX:    prdata = 32'(cfg.short_tap_max);
      REG_LONG_PRESS_TIME:  prdata = 32'(cfg.long_press_time);
      REG_VERY_LONG_TIME:   prdata = 32'(cfg.very_long_press_time);
      REG_DOUBLE_TAP_WIN:   prdata = 32'(cfg.double_tap_window);
      REG_TOUCH_MARGIN:     prdata = 32'(cfg.touch_margin);
      REG_INITIAL_BASELINE: prdata = 32'(initial_baseline);
    endcase
  end

endmodule

@@ rtl/tbgd_core.sv @@
module tbgd_core
  import tbgd_pkg::*;
#(
  parameter int BASELINE_FRAC_BITS = DEF_BASELINE_FRAC_BITS,
  parameter int TIME_BITS          = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  base_load_t           base_load,
  input  logic                 advance,
  input  logic [TIME_BITS-1:0] now,
  input  logic [READING_W-1:0] reading,
  output result_t              result
);

  localparam int F  = BASELINE_FRAC_BITS;
  localparam int BW = LEVEL_W + F;
  localparam int PW = BW + 16;
  localparam int SW = BW + 17;

  function automatic logic [CMP_W-1:0] tdiff(input logic [TIME_BITS-1:0] a,
                                             input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return CMP_W'(d);
  endfunction

  logic [BW-1:0]        baseline_fx, baseline_fx_next;
  logic [TIME_BITS-1:0] last_check_time, last_check_time_next;
  logic [TIME_BITS-1:0] last_change_time, last_change_time_next;
  logic [TIME_BITS-1:0] press_start_time, press_start_time_next;
  logic [TIME_BITS-1:0] last_tap_release_time, last_tap_release_time_next;
  logic raw_touched, raw_touched_next;
  logic stable_touched, stable_touched_next;
  logic tap_pending, tap_pending_next;
  logic long_done, long_done_next;
  logic very_long_done, very_long_done_next;

  logic              eval;
  logic              pressed;
  logic [16:0]       thr_int;
  logic [PW-1:0]     keep_prod;
  logic [28:0]       new_prod;
  logic [SW-1:0]     filt_sum;
  logic [BW-1:0]     filt_out;
  logic [CMP_W-1:0]  held;
  logic              done;
  gesture_ev_t       ev;

  assign eval = tdiff(now, last_check_time) >= CMP_W'(cfg.check_interval);

  // touched when reading + margin sits at or below the baseline
  assign thr_int = 17'(reading) + 17'(cfg.touch_margin);
  assign pressed = {thr_int, {F{1'b0}}} <= {1'b0, baseline_fx};

  // exponential average, rounded half up
  assign keep_prod = PW'(baseline_fx) * PW'(ALPHA_KEEP_W);
  assign new_prod  = 29'(reading) * 29'(ALPHA_NUM_W);
  assign filt_sum  = SW'(keep_prod) + (SW'(new_prod) << F) + SW'(ROUND_HALF_W);
  assign filt_out  = BW'(filt_sum >> ALPHA_SHIFT);

  always_comb begin
    baseline_fx_next           = baseline_fx;
    last_check_time_next       = last_check_time;
    last_change_time_next      = last_change_time;
    press_start_time_next      = press_start_time;
    last_tap_release_time_next = last_tap_release_time;
    raw_touched_next           = raw_touched;
    stable_touched_next        = stable_touched;
    tap_pending_next           = tap_pending;
    long_done_next             = long_done;
    very_long_done_next        = very_long_done;
    ev                         = EV_NONE;
    done                       = 1'b0;
    held                       = '0;

    if (eval) begin
      last_check_time_next = now;
      if (!pressed) baseline_fx_next = filt_out;
      if (pressed != raw_touched) begin
        raw_touched_next      = pressed;
        last_change_time_next = now;
      end

      if (tdiff(now, last_change_time_next) >= CMP_W'(cfg.debounce_time) &&
          stable_touched != raw_touched_next) begin
        stable_touched_next = raw_touched_next;
        if (raw_touched_next) begin
          press_start_time_next = now;
          long_done_next        = 1'b0;
          very_long_done_next   = 1'b0;
        end else if (!long_done && !very_long_done &&
                     tdiff(now, press_start_time) <= CMP_W'(cfg.short_tap_max)) begin
          if (tap_pending &&
              tdiff(now, last_tap_release_time) <= CMP_W'(cfg.double_tap_window)) begin
            tap_pending_next = 1'b0;
            ev               = EV_DOUBLE_TAP;
            done             = 1'b1;
          end else begin
            tap_pending_next           = 1'b1;
            last_tap_release_time_next = now;
          end
        end else begin
          tap_pending_next = 1'b0;
        end
      end

      held = tdiff(now, press_start_time_next);
      if (!done && stable_touched_next) begin
        if (!very_long_done_next && held >= CMP_W'(cfg.very_long_press_time)) begin
          very_long_done_next = 1'b1;
          long_done_next      = 1'b1;
          tap_pending_next    = 1'b0;
          ev                  = EV_VERY_LONG_PRESS;
          done                = 1'b1;
        end else if (!long_done_next && held >= CMP_W'(cfg.long_press_time)) begin
          long_done_next   = 1'b1;
          tap_pending_next = 1'b0;
          ev               = EV_LONG_PRESS;
          done             = 1'b1;
        end
      end

      if (!done && tap_pending_next &&
          tdiff(now, last_tap_release_time_next) > CMP_W'(cfg.double_tap_window)) begin
        tap_pending_next = 1'b0;
        ev               = EV_SHORT_TAP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_fx           <= {RST_INITIAL_BASELINE, {F{1'b0}}};
      last_check_time       <= '0;
      last_change_time      <= '0;
      press_start_time      <= '0;
      last_tap_release_time <= '0;
      raw_touched           <= 1'b0;
      stable_touched        <= 1'b0;
      tap_pending           <= 1'b0;
      long_done             <= 1'b0;
      very_long_done        <= 1'b0;
    end else if (base_load.load) begin
      baseline_fx           <= {base_load.value, {F{1'b0}}};
      last_check_time       <= '0;
      last_change_time      <= '0;
      press_start_time      <= '0;
      last_tap_release_time <= '0;
    end else if (advance) begin
      baseline_fx           <= baseline_fx_next;
      last_check_time       <= last_check_time_next;
      last_change_time      <= last_change_time_next;
      press_start_time      <= press_start_time_next;
      last_tap_release_time <= last_tap_release_time_next;
      raw_touched           <= raw_touched_next;
      stable_touched        <= stable_touched_next;
      tap_pending           <= tap_pending_next;
      long_done             <= long_done_next;
      very_long_done        <= very_long_done_next;
    end
  end

  assign result.ev     = ev;
  assign result.stable = stable_touched_next;
  assign result.raw    = raw_touched_next;
  assign result.level  = baseline_fx_next[BW-1:F];

  // a very long press always counts as a long one too
  a_vlong_implies_long: assert property (@(posedge clk) disable iff (rst)
    very_long_done |-> long_done)
    else $error("very long press done without long press done");

  // the baseline only moves on an evaluated sample that is not pressed, or on a baseline load
  a_baseline_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && !base_load.load && (!eval || pressed)) |=> $stable(baseline_fx))
    else $error("baseline moved while pressed or skipped");

endmodule

@@ rtl/touch_button_gesture_detector_unit.sv @@
// Capacitive touch button gesture detector. Each request on the s_ side carries a
// millisecond timestamp and a touch reading; exactly one result per request leaves
// on the m_ side with the gesture code, the debounced and raw touch state and the
// integer part of the tracked baseline. The unit takes one request per clock while
// m_tready is high: the input register feeds a single pass of baseline filter (two
// constant multiplies), press test and gesture logic into the result register, and
// m_tready low only stalls once both registers are full. Write the
// registers over the APB port while no request is in flight; writing the initial
// baseline register reloads the baseline and clears all stored timestamps.
module touch_button_gesture_detector_unit
  import tbgd_pkg::*;
#(
  parameter int BASELINE_FRAC_BITS = DEF_BASELINE_FRAC_BITS,
  parameter int TIME_BITS          = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // now_time[31:0], reading[47:32]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // event_res[2:0], stable_touch[3],
                                           // raw_touch[4], baseline_level[20:5], zero
);

  cfg_t                 cfg;
  base_load_t           base_load;
  result_t              result;
  result_t              out_res;
  logic                 in_valid;
  logic [TIME_BITS-1:0] in_now;
  logic [READING_W-1:0] in_reading;
  logic                 advance;

  tbgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .base_load (base_load)
  );

  // item moves from the input register to the result register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now     <= s_tdata[TIME_BITS-1:0];
      in_reading <= s_tdata[NOW_W +: READING_W];
    end
  end

  tbgd_core #(
    .BASELINE_FRAC_BITS (BASELINE_FRAC_BITS),
    .TIME_BITS          (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .base_load (base_load),
    .advance   (advance),
    .now       (in_now),
    .reading   (in_reading),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= result;
  end

  assign m_tdata = {3'b000, out_res.level, out_res.raw, out_res.stable, out_res.ev};

  // a waiting input item is never dropped
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input register lost an item");

  // a double tap ends on a release, long presses happen while held
  a_double_released: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.ev == EV_DOUBLE_TAP) |-> !out_res.stable)
    else $error("double tap reported while touched");

  a_long_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.ev == EV_LONG_PRESS || out_res.ev == EV_VERY_LONG_PRESS))
      |-> out_res.stable)
    else $error("long press reported while released");

endmodule
